>>> sv/bfa_pkg.sv
// Shared constants, types and sequencer states of the buddy frame allocator.
package bfa_pkg;

    localparam int FRAME_COUNT_DEF = 1024;
    localparam int MAX_ORDER_DEF   = 5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ORDER = 2'd1;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd2;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] block_index;
    } res_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SPLIT_TAG,
        ST_SPLIT_G,
        ST_SPLIT_PUSHG,
        ST_SPLIT_NEXT,
        ST_TAKE,
        ST_MARK,
        ST_FREE_CHK,
        ST_MERGE,
        ST_MERGE_CHK,
        ST_MERGE_U2,
        ST_MERGE_LO,
        ST_MERGE_HI,
        ST_UNL_RD,
        ST_UNL_WR,
        ST_UNL_CLR,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_DONE
    } state_t;

endpackage

>>> sv/bfa_ram.sv
// Generic single-port RAM with registered read.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bfa_ctrl.sv
// Allocator sequencer: tag and link memories, free-list heads and tails, list operations.
module bfa_ctrl #(
    parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
    parameter int MAX_ORDER   = bfa_pkg::MAX_ORDER_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_action,
    input  logic [2:0]    in_order,
    input  logic [9:0]    in_frame,
    output logic          idle,
    input  logic          out_free,
    output logic          res_valid,
    output bfa_pkg::res_t res
);
    import bfa_pkg::*;

    localparam int IW   = $clog2(FRAME_COUNT);
    localparam int LW   = $clog2(FRAME_COUNT + 1);
    localparam int TW   = $clog2(MAX_ORDER + 3);
    localparam int OW   = $clog2(MAX_ORDER + 1);
    localparam int CW   = MAX_ORDER;
    localparam int TOP  = 1 << MAX_ORDER;
    localparam int NBLK = FRAME_COUNT / TOP;
    localparam int LAST_HEAD = (NBLK == 0) ? FRAME_COUNT : (NBLK - 1) * TOP;
    localparam logic [LW-1:0] LINK_NULL = LW'(FRAME_COUNT);
    localparam logic [TW-1:0] TAG_BODY  = TW'(MAX_ORDER + 1);
    localparam logic [TW-1:0] TAG_ALLOC = TW'(MAX_ORDER + 2);

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [LW-1:0] head_reg [0:MAX_ORDER];
    logic [LW-1:0] head_next [0:MAX_ORDER];
    logic [LW-1:0] tail_reg [0:MAX_ORDER];
    logic [LW-1:0] tail_next [0:MAX_ORDER];
    logic [IW-1:0] uf_reg, uf_next, f_reg, f_next, g_reg, g_next;
    logic [IW-1:0] idx_reg, idx_next, b_reg, b_next, t_reg, t_next;
    logic [OW-1:0] uk_reg, uk_next, u_reg, u_next, k_reg, k_next, i_reg, i_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    status_reg, status_next;
    logic [9:0]    index_reg, index_next;

    // memory ports
    logic          tag_en, tag_we, nx_en, nx_we, pv_en, pv_we;
    logic [IW-1:0] tag_addr, nx_addr, pv_addr;
    logic [TW-1:0] tag_wdata, tag_rdata;
    logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

    bfa_ram #(.WIDTH(TW), .DEPTH(FRAME_COUNT)) u_tag (
        .aclk(aclk), .en(tag_en), .we(tag_we), .addr(tag_addr),
        .wdata(tag_wdata), .rdata(tag_rdata)
    );
    bfa_ram #(.WIDTH(LW), .DEPTH(FRAME_COUNT)) u_next_link (
        .aclk(aclk), .en(nx_en), .we(nx_we), .addr(nx_addr),
        .wdata(nx_wdata), .rdata(nx_rdata)
    );
    bfa_ram #(.WIDTH(LW), .DEPTH(FRAME_COUNT)) u_prev_link (
        .aclk(aclk), .en(pv_en), .we(pv_we), .addr(pv_addr),
        .wdata(pv_wdata), .rdata(pv_rdata)
    );

    // shared datapath terms
    logic          accept, order_bad, fidx_bad, found, clr_head;
    logic [OW-1:0] found_u, u_dec;
    logic [31:0]   g_wide, b_wide, mark_wide, last_cnt, clr_wide;
    logic [IW-1:0] lo_frame, hi_frame;
    logic          push_link;
    logic [LW-1:0] push_tail;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign order_bad = 32'(in_order) > MAX_ORDER;
    assign fidx_bad  = 32'(in_frame) >= FRAME_COUNT;
    assign u_dec     = u_reg - OW'(1);
    assign g_wide    = 32'(f_reg) + (32'd1 << u_dec);
    assign b_wide    = 32'(idx_reg) ^ (32'd1 << i_reg);
    assign mark_wide = 32'(f_reg) + 32'(cnt_reg);
    assign last_cnt  = (32'd1 << k_reg) - 32'd1;
    assign lo_frame  = (b_reg < idx_reg) ? b_reg : idx_reg;
    assign hi_frame  = (b_reg < idx_reg) ? idx_reg : b_reg;
    assign push_tail = tail_reg[uk_reg];
    assign push_link = (head_reg[uk_reg] != LINK_NULL) && (32'(push_tail) < FRAME_COUNT);
    assign clr_wide  = 32'(clr_reg);
    assign clr_head  = ((clr_wide & (TOP - 1)) == 0) && (clr_wide + TOP <= FRAME_COUNT);

    // smallest larger order with a free block
    always_comb begin
        found   = 1'b0;
        found_u = '0;
        for (int j = 0; j <= MAX_ORDER; j++) begin
            if (!found && j > 32'(in_order) && head_reg[j] != LINK_NULL) begin
                found   = 1'b1;
                found_u = OW'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
            clr_reg   <= '0;
            for (int j = 0; j <= MAX_ORDER; j++) begin
                if (j == MAX_ORDER && NBLK != 0) begin
                    head_reg[j] <= '0;
                    tail_reg[j] <= LW'(LAST_HEAD);
                end else begin
                    head_reg[j] <= LINK_NULL;
                    tail_reg[j] <= LINK_NULL;
                end
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        uf_reg     <= uf_next;
        f_reg      <= f_next;
        g_reg      <= g_next;
        idx_reg    <= idx_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        uk_reg     <= uk_next;
        u_reg      <= u_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    // next state and sequencer registers
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        uf_next     = uf_reg;
        f_next      = f_reg;
        g_next      = g_reg;
        idx_next    = idx_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        uk_next     = uk_reg;
        u_next      = u_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        index_next  = index_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + IW'(1);
                if (clr_wide == FRAME_COUNT - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    status_next = STATUS_OK;
                    index_next  = '0;
                    if (in_action == ACTION_ALLOC) begin
                        k_next = OW'(in_order);
                        if (order_bad) begin
                            status_next = STATUS_BAD_ORDER;
                            state_next  = ST_DONE;
                        end else if (head_reg[OW'(in_order)] != LINK_NULL) begin
                            state_next = ST_TAKE;
                        end else if (!found) begin
                            status_next = STATUS_NO_MEMORY;
                            state_next  = ST_DONE;
                        end else begin
                            u_next     = found_u;
                            state_next = ST_SPLIT;
                        end
                    end else begin
                        idx_next = IW'(32'(in_frame));
                        if (fidx_bad) begin
                            status_next = STATUS_NOT_ALLOC;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_FREE_CHK;
                        end
                    end
                end
            end
            ST_SPLIT: begin
                f_next     = IW'(head_reg[u_reg]);
                uf_next    = IW'(head_reg[u_reg]);
                uk_next    = u_reg;
                ret_next   = ST_SPLIT_TAG;
                state_next = ST_UNL_RD;
            end
            ST_SPLIT_TAG: begin
                if (g_wide >= FRAME_COUNT) begin
                    status_next = STATUS_NO_MEMORY;
                    state_next  = ST_DONE;
                end else begin
                    u_next     = u_dec;
                    g_next     = IW'(g_wide);
                    state_next = ST_SPLIT_G;
                end
            end
            ST_SPLIT_G: begin
                uf_next    = f_reg;
                uk_next    = u_reg;
                ret_next   = ST_SPLIT_PUSHG;
                state_next = ST_PUSH_A;
            end
            ST_SPLIT_PUSHG: begin
                uf_next    = g_reg;
                uk_next    = u_reg;
                ret_next   = ST_SPLIT_NEXT;
                state_next = ST_PUSH_A;
            end
            ST_SPLIT_NEXT: begin
                state_next = (u_reg > k_reg) ? ST_SPLIT : ST_TAKE;
            end
            ST_TAKE: begin
                if (32'(head_reg[k_reg]) >= FRAME_COUNT) begin
                    status_next = STATUS_NO_MEMORY;
                    state_next  = ST_DONE;
                end else begin
                    f_next     = IW'(head_reg[k_reg]);
                    uf_next    = IW'(head_reg[k_reg]);
                    uk_next    = k_reg;
                    cnt_next   = '0;
                    ret_next   = ST_MARK;
                    state_next = ST_UNL_RD;
                end
            end
            ST_MARK: begin
                cnt_next = cnt_reg + CW'(1);
                if (32'(cnt_reg) == last_cnt) begin
                    index_next = 10'(32'(f_reg));
                    state_next = ST_DONE;
                end
            end
            ST_FREE_CHK: begin
                if (tag_rdata != TAG_ALLOC) begin
                    status_next = STATUS_NOT_ALLOC;
                    state_next  = ST_DONE;
                end else begin
                    uf_next    = idx_reg;
                    uk_next    = '0;
                    i_next     = '0;
                    ret_next   = ST_MERGE;
                    state_next = ST_PUSH_A;
                end
            end
            ST_MERGE: begin
                if (32'(i_reg) == MAX_ORDER || b_wide >= FRAME_COUNT) begin
                    state_next = ST_DONE;
                end else begin
                    b_next     = IW'(b_wide);
                    state_next = ST_MERGE_CHK;
                end
            end
            ST_MERGE_CHK: begin
                if (tag_rdata != TW'(i_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    uf_next    = b_reg;
                    uk_next    = i_reg;
                    ret_next   = ST_MERGE_U2;
                    state_next = ST_UNL_RD;
                end
            end
            ST_MERGE_U2: begin
                uf_next    = idx_reg;
                uk_next    = i_reg;
                ret_next   = ST_MERGE_LO;
                state_next = ST_UNL_RD;
            end
            ST_MERGE_LO: begin
                state_next = ST_MERGE_HI;
            end
            ST_MERGE_HI: begin
                uf_next    = lo_frame;
                uk_next    = i_reg + OW'(1);
                idx_next   = lo_frame;
                i_next     = i_reg + OW'(1);
                ret_next   = ST_MERGE;
                state_next = ST_PUSH_A;
            end
            ST_UNL_RD: begin
                state_next = ST_UNL_WR;
            end
            ST_UNL_WR: begin
                if (head_reg[uk_reg] == LW'(uf_reg)) begin
                    head_next[uk_reg] = nx_rdata;
                end
                if (tail_reg[uk_reg] == LW'(uf_reg)) begin
                    tail_next[uk_reg] = pv_rdata;
                end
                state_next = ST_UNL_CLR;
            end
            ST_UNL_CLR: begin
                state_next = ret_reg;
            end
            ST_PUSH_A: begin
                tail_next[uk_reg] = LW'(uf_reg);
                if (push_link) begin
                    t_next     = IW'(push_tail);
                    state_next = ST_PUSH_B;
                end else begin
                    head_next[uk_reg] = LW'(uf_reg);
                    state_next        = ret_reg;
                end
            end
            ST_PUSH_B: begin
                state_next = ret_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port drive
    always_comb begin
        tag_en    = 1'b0;
        tag_we    = 1'b0;
        tag_addr  = uf_reg;
        tag_wdata = '0;
        nx_en     = 1'b0;
        nx_we     = 1'b0;
        nx_addr   = uf_reg;
        nx_wdata  = LINK_NULL;
        pv_en     = 1'b0;
        pv_we     = 1'b0;
        pv_addr   = uf_reg;
        pv_wdata  = LINK_NULL;
        case (state_reg)
            ST_CLEAR: begin
                tag_en    = 1'b1;
                tag_we    = 1'b1;
                tag_addr  = clr_reg;
                tag_wdata = clr_head ? TW'(MAX_ORDER) : TAG_BODY;
                nx_en     = 1'b1;
                nx_we     = 1'b1;
                nx_addr   = clr_reg;
                nx_wdata  = (clr_head && clr_wide + 2 * TOP <= FRAME_COUNT)
                          ? LW'(clr_wide + TOP) : LINK_NULL;
                pv_en     = 1'b1;
                pv_we     = 1'b1;
                pv_addr   = clr_reg;
                pv_wdata  = (clr_head && clr_wide != 0) ? LW'(clr_wide - TOP) : LINK_NULL;
            end
            ST_IDLE: begin
                // tag fetch for a free request
                tag_en   = accept && (in_action == ACTION_FREE) && !fidx_bad;
                tag_addr = IW'(32'(in_frame));
            end
            ST_SPLIT_TAG: begin
                tag_en    = g_wide < FRAME_COUNT;
                tag_we    = 1'b1;
                tag_addr  = f_reg;
                tag_wdata = TW'(u_dec);
            end
            ST_SPLIT_G: begin
                tag_en    = 1'b1;
                tag_we    = 1'b1;
                tag_addr  = g_reg;
                tag_wdata = TW'(u_reg);
            end
            ST_MARK: begin
                tag_en    = mark_wide < FRAME_COUNT;
                tag_we    = 1'b1;
                tag_addr  = IW'(mark_wide);
                tag_wdata = TAG_ALLOC;
            end
            ST_FREE_CHK: begin
                tag_en    = tag_rdata == TAG_ALLOC;
                tag_we    = 1'b1;
                tag_addr  = idx_reg;
                tag_wdata = '0;
            end
            ST_MERGE: begin
                tag_en   = !(32'(i_reg) == MAX_ORDER || b_wide >= FRAME_COUNT);
                tag_addr = IW'(b_wide);
            end
            ST_MERGE_LO: begin
                tag_en    = 1'b1;
                tag_we    = 1'b1;
                tag_addr  = lo_frame;
                tag_wdata = TW'(i_reg) + TW'(1);
            end
            ST_MERGE_HI: begin
                tag_en    = 1'b1;
                tag_we    = 1'b1;
                tag_addr  = hi_frame;
                tag_wdata = TAG_BODY;
            end
            ST_UNL_RD: begin
                nx_en = 1'b1;
                pv_en = 1'b1;
            end
            ST_UNL_WR: begin
                // bridge the neighbours around the unlinked frame
                nx_en    = 32'(pv_rdata) < FRAME_COUNT;
                nx_we    = 1'b1;
                nx_addr  = IW'(pv_rdata);
                nx_wdata = nx_rdata;
                pv_en    = 32'(nx_rdata) < FRAME_COUNT;
                pv_we    = 1'b1;
                pv_addr  = IW'(nx_rdata);
                pv_wdata = pv_rdata;
            end
            ST_UNL_CLR: begin
                nx_en = 1'b1;
                nx_we = 1'b1;
                pv_en = 1'b1;
                pv_we = 1'b1;
            end
            ST_PUSH_A: begin
                nx_en    = 1'b1;
                nx_we    = 1'b1;
                pv_en    = 1'b1;
                pv_we    = 1'b1;
                pv_wdata = push_link ? push_tail : LINK_NULL;
            end
            ST_PUSH_B: begin
                nx_en    = 1'b1;
                nx_we    = 1'b1;
                nx_addr  = t_reg;
                nx_wdata = LW'(uf_reg);
            end
            default: begin
                tag_en = 1'b0;
            end
        endcase
    end

    assign idle            = state_reg == ST_IDLE;
    assign res_valid       = state_reg == ST_DONE;
    assign res.status      = status_reg;
    assign res.block_index = index_reg;

endmodule

>>> sv/buddy_frame_allocator.sv
// Buddy frame allocator top level: stream ports and result register.
//
// Buddy allocator over FRAME_COUNT frames, block orders 0 to MAX_ORDER, one
// FIFO free list per order kept in tag, next-link and prev-link memories
// (single port, registered read). A request is a transfer on the s_ channel:
// tuser says allocate (0) or free one frame (1). Each request gives exactly
// one result transfer on the m_ channel carrying status and block index.
// After reset a clearing pass over every frame loads the initial free
// lists; s_tready stays low meanwhile. One request is worked at a time
// by the sequencer; its memory port sets the cost. An allocate from a
// non-empty list unlinks the head block, then writes one tag per frame; each
// split level adds an unlink, two tag writes and two appends. A free checks
// the tag and appends the frame, then each merge level reads the buddy's tag,
// unlinks both halves, writes two tags and appends the merged block. The
// next request is taken while a result still waits on the m_ side.
module buddy_frame_allocator #(
    parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF,
    parameter int MAX_ORDER   = bfa_pkg::MAX_ORDER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] order, [12:3] frame_index, rest zero
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [11:2] block_index, rest zero
);
    import bfa_pkg::*;

    logic  idle, out_free, res_valid;
    res_t  res;
    logic  m_valid_reg, m_valid_next;
    res_t  m_data_reg, m_data_next;

    // result register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    bfa_ctrl #(
        .FRAME_COUNT(FRAME_COUNT),
        .MAX_ORDER  (MAX_ORDER)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_action(s_tuser[0]),
        .in_order (s_tdata[2:0]),
        .in_frame (s_tdata[12:3]),
        .idle     (idle),
        .out_free (out_free),
        .res_valid(res_valid),
        .res      (res)
    );

    assign s_tready = idle;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg.block_index, m_data_reg.status};

endmodule

>>> tb/tb_buddy_frame_allocator.sv
// Testbench for the buddy frame allocator: random alloc/free traffic checked against a software model.
`timescale 1ns / 1ps

module tb_buddy_frame_allocator;
    import bfa_pkg::*;

    localparam int FRAMES   = 1024;
    localparam int TOP      = 5;
    localparam int NULLIDX  = FRAMES;
    localparam int TAG_BODY = TOP + 1;
    localparam int TAG_USED = TOP + 2;
    localparam int N_ITEMS  = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    // Allocator state mirror plus the queue of predicted result transfers.
    class alloc_scoreboard;
        int unsigned tag [FRAMES];
        int unsigned nxt [FRAMES];
        int unsigned prv [FRAMES];
        int unsigned head [TOP+1];
        int unsigned tail [TOP+1];
        res_t        pending [$];
        int          mismatches;

        function void push_free(int unsigned f, int unsigned k);
            int unsigned t;
            t = tail[k];
            nxt[f] = NULLIDX;
            if (head[k] == NULLIDX || t >= FRAMES) begin
                prv[f] = NULLIDX;
                head[k] = f;
            end else begin
                prv[f] = t;
                nxt[t] = f;
            end
            tail[k] = f;
        endfunction

        function void unlink(int unsigned f, int unsigned k);
            int unsigned p, n;
            p = prv[f];
            n = nxt[f];
            if (p < FRAMES) nxt[p] = n;
            if (n < FRAMES) prv[n] = p;
            if (head[k] == f) head[k] = n;
            if (tail[k] == f) tail[k] = p;
            prv[f] = NULLIDX;
            nxt[f] = NULLIDX;
        endfunction

        function void clear_state();
            for (int i = 0; i < FRAMES; i++) begin
                tag[i] = TAG_BODY;
                nxt[i] = NULLIDX;
                prv[i] = NULLIDX;
            end
            for (int i = 0; i <= TOP; i++) begin
                head[i] = NULLIDX;
                tail[i] = NULLIDX;
            end
            for (int i = 0; i + (1 << TOP) <= FRAMES; i += (1 << TOP)) begin
                tag[i] = TOP;
                push_free(i, TOP);
            end
            mismatches = 0;
        endfunction

        function logic [1:0] allocate(int unsigned k, output int unsigned first);
            int unsigned u, f, g;
            first = 0;
            if (k > TOP) return STATUS_BAD_ORDER;
            if (head[k] == NULLIDX) begin
                u = k + 1;
                while (u <= TOP && head[u] == NULLIDX) u++;
                if (u > TOP) return STATUS_NO_MEMORY;
                while (u > k) begin
                    f = head[u];
                    unlink(f, u);
                    u--;
                    g = f + (1 << u);
                    if (g >= FRAMES) return STATUS_NO_MEMORY;
                    tag[f] = u;
                    tag[g] = u;
                    push_free(f, u);
                    push_free(g, u);
                end
            end
            f = head[k];
            if (f >= FRAMES) return STATUS_NO_MEMORY;
            unlink(f, k);
            for (int i = 0; i < (1 << k); i++)
                if (f + i < FRAMES) tag[f + i] = TAG_USED;
            first = f;
            return STATUS_OK;
        endfunction

        function logic [1:0] release_frame(int unsigned idx);
            int unsigned b, lo, hi;
            if (idx >= FRAMES || tag[idx] != TAG_USED) return STATUS_NOT_ALLOC;
            tag[idx] = 0;
            push_free(idx, 0);
            for (int i = 0; i < TOP; i++) begin
                b = idx ^ (1 << i);
                if (b >= FRAMES || tag[b] != i) break;
                unlink(b, i);
                unlink(idx, i);
                lo = b < idx ? b : idx;
                hi = b < idx ? idx : b;
                tag[lo] = i + 1;
                tag[hi] = TAG_BODY;
                push_free(lo, i + 1);
                idx = lo;
            end
            return STATUS_OK;
        endfunction

        // note an accepted request and queue its predicted result
        function void note_request(logic act, logic [2:0] ord, logic [9:0] fidx);
            res_t r;
            int unsigned first;
            if (act == ACTION_ALLOC) begin
                r.status = allocate(32'(ord), first);
                r.block_index = (r.status == STATUS_OK) ? first[9:0] : 10'd0;
            end else begin
                r.status = release_frame(32'(fidx));
                r.block_index = 10'd0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            res_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            want = pending.pop_front();
            if (data[1:0] !== want.status || data[11:2] !== want.block_index
                    || data[15:12] !== 4'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d index %0d, got status %0d index %0d",
                             want.status, want.block_index, data[1:0], data[11:2]);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    alloc_scoreboard sb;
    longint cycles = 0;
    bit     idle_on;      // random gaps enabled
    int     hold_reqs;    // long receiver hold-offs requested by the sender side
    int     hold_seen;    // hold-offs already started by the sink
    int     hold_left;

    // frames we believe are held, so frees mostly hit live allocations
    int unsigned held [$];

    buddy_frame_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // cycle counter and watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_buddy_frame_allocator: FAIL");
            $finish;
        end
    end

    // sink: random back-pressure, a long hold-off on request, checks each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_reqs != hold_seen) begin
                hold_seen <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
            end
        end
    end

    // one request transfer; gaps before it when idling is on
    task automatic send_req(logic act, logic [2:0] ord, logic [9:0] fidx);
        while (idle_on && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'd0, fidx, ord};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, ord, fidx);
        if (act == ACTION_ALLOC && sb.pending[$].status == STATUS_OK)
            held.push_back(32'(sb.pending[$].block_index));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // random mix: mostly well-formed alloc/free of live frames, some junk
    task automatic random_req();
        int sel, pick;
        sel = int'($urandom_range(99));
        if (sel < 45) begin
            send_req(ACTION_ALLOC,
                     3'(($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(7)),
                     10'($urandom));
        end else if (sel < 90 && held.size() > 0) begin
            pick = int'($urandom_range(held.size() - 1));
            // sometimes free a frame inside the block rather than its first
            send_req(ACTION_FREE, 3'($urandom),
                     10'(held[pick] + (($urandom_range(3) == 0) ? $urandom_range(3) : 0)));
            held.delete(pick);
        end else begin
            send_req(1'($urandom_range(1)), 3'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        idle_on   = 1'b0;
        hold_reqs = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every order, bad orders, bad frees, buddy merges
        for (int k = 0; k <= 7; k++) send_req(ACTION_ALLOC, 3'(k), 10'h3ff);
        send_req(ACTION_FREE, 3'd7, 10'd1023);   // never allocated
        send_req(ACTION_FREE, 3'd0, 10'd0);       // part of order-0 block
        send_req(ACTION_FREE, 3'd0, 10'd0);       // double free
        send_req(ACTION_ALLOC, 3'd0, 10'd0);
        send_req(ACTION_ALLOC, 3'd0, 10'd0);
        for (int i = 0; i < 4; i++)
            send_req(ACTION_FREE, 3'd0, 10'(held[held.size()-1-i]));
        send_req(ACTION_FREE, 3'd0, 10'd1023);
        send_req(ACTION_ALLOC, 3'd5, 10'd0);

        // exhaust memory with order-5 blocks, then hit no-memory
        for (int i = 0; i < 34; i++) send_req(ACTION_ALLOC, 3'd5, 10'($urandom));
        wait_drained();
        // free each frame singly: single-frame free leaves the rest held
        while (held.size() > 0) begin
            send_req(ACTION_FREE, 3'd0, 10'(held[0]));
            held.delete(0);
        end

        // random, no idling at first
        for (int i = 0; i < 300; i++) random_req();
        idle_on = 1'b1;
        for (int i = 0; i < 400; i++) random_req();

        // receiver holds off a long stretch while requests keep coming
        hold_reqs = hold_reqs + 1;
        for (int i = 0; i < 40; i++) random_req();

        // sender pauses until every result is in
        wait_drained();
        for (int i = 0; i < 700; i++) random_req();

        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_buddy_frame_allocator: PASS");
        else
            $display("tb_buddy_frame_allocator: FAIL");
        $finish;
    end
endmodule
